>>> design/swpb_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and control types for the sliding-window PDU buffer.
package swpb_pkg;

    localparam int MAX_SLOTS_DEF = 64;
    localparam int PDU_BYTES_DEF = 2048;
    localparam int RESET_WINDOW  = 16;

    typedef enum logic [2:0] {
        OP_WRITE_BYTE  = 3'd0,
        OP_COMMIT      = 3'd1,
        OP_ADVANCE     = 3'd2,
        OP_READ_BYTE   = 3'd3,
        OP_SET_CURRENT = 3'd4,
        OP_SET_UPPER   = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OUTSIDE   = 2'd1,
        ST_NOT_BELOW = 2'd2
    } status_t;

    // Slot table commands
    typedef struct packed {
        logic commit;       // mark slot valid and store its length
        logic advance;      // clear the slots that leave the window
        logic clear_every;  // advance that drops the whole window
        logic clear_all;    // window size rewritten
    } slot_ctrl_t;

endpackage

>>> design/swpb_byte_mem.sv
`timescale 1ns / 1ps
// PDU byte storage: one synchronous RAM, slot-major, registered read.
module swpb_byte_mem #(
    parameter int ADDR_W = 17
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [7:0]        wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [7:0]        rdata
);

    logic [7:0] mem [2**ADDR_W];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> design/swpb_slot_table.sv
`timescale 1ns / 1ps
// Per-slot metadata: length RAM plus valid flags with range clear on advance.
module swpb_slot_table #(
    parameter int MAX_SLOTS = 64,
    parameter int SLOT_W    = 6,
    parameter int WS_W      = 7,
    parameter int LEN_W     = 12
) (
    input  logic                clk,
    input  logic                rst_n,
    input  swpb_pkg::slot_ctrl_t ctrl,
    input  logic [SLOT_W-1:0]   commit_slot,
    input  logic [LEN_W-1:0]    commit_len,
    input  logic [SLOT_W-1:0]   base,
    input  logic [WS_W-1:0]     shift,
    input  logic [WS_W-1:0]     ws,
    input  logic [SLOT_W-1:0]   rd_slot,
    output logic [LEN_W-1:0]    rd_len,
    output logic                rd_valid
);

    logic [LEN_W-1:0]     len_mem [MAX_SLOTS];
    logic [LEN_W-1:0]     rd_len_reg;
    logic                 rd_valid_reg;
    logic [MAX_SLOTS-1:0] valid_reg;
    logic [MAX_SLOTS-1:0] valid_next;
    logic [MAX_SLOTS-1:0] drop_mask;

    // Slot i leaves when its distance from base (mod ws) is below the shift, or on clear_every
    always_comb
    begin
        logic [WS_W:0] idx_w;
        logic [WS_W:0] base_w;
        logic [WS_W:0] ws_w;
        logic [WS_W:0] rel;
        for (int i = 0; i < MAX_SLOTS; i++)
        begin
            idx_w  = (WS_W + 1)'(i);
            base_w = {1'b0, WS_W'(base)};
            ws_w   = {1'b0, ws};
            rel    = (idx_w >= base_w) ? (idx_w - base_w) : (idx_w + ws_w - base_w);
            drop_mask[i] = ctrl.clear_every || (rel < {1'b0, shift});
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (ctrl.clear_all)
        begin
            valid_next = '0;
        end
        else if (ctrl.advance)
        begin
            valid_next = valid_reg & ~drop_mask;
        end
        else if (ctrl.commit)
        begin
            valid_next[commit_slot] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg    <= valid_next;
            rd_valid_reg <= valid_reg[rd_slot];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.commit)
        begin
            len_mem[commit_slot] <= commit_len;
        end
        rd_len_reg <= len_mem[rd_slot];
    end

    assign rd_len   = rd_len_reg;
    assign rd_valid = rd_valid_reg;

endmodule

>>> design/swpb_mod_unit.sv
`timescale 1ns / 1ps
// Bit-serial remainder unit: 32-bit value modulo the window size, one bit a cycle.
module swpb_mod_unit #(
    parameter int WS_W = 7
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [31:0]     dividend,
    input  logic [WS_W-1:0] divisor,
    output logic            done,
    output logic [WS_W-1:0] rem
);

    logic            busy_reg;
    logic [5:0]      cnt_reg;
    logic [31:0]     dvd_reg;
    logic [WS_W-1:0] dsr_reg;
    logic [WS_W-1:0] rem_reg;
    logic [WS_W:0]   trial;
    logic [WS_W:0]   diff;

    assign trial = {rem_reg, dvd_reg[31]};
    assign diff  = trial - {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            dvd_reg  <= '0;
            dsr_reg  <= '0;
            rem_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= 6'd32;
            dvd_reg  <= dividend;
            dsr_reg  <= divisor;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                dvd_reg <= {dvd_reg[30:0], 1'b0};
                rem_reg <= (trial >= {1'b0, dsr_reg}) ? WS_W'(diff) : WS_W'(trial);
            end
            else
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign done = busy_reg && (cnt_reg == '0);
    assign rem  = rem_reg;

`ifndef SYNTHESIS
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("remainder unit restarted while busy");
`endif

endmodule

>>> design/sliding_window_pdu_buffer_top.sv
`timescale 1ns / 1ps
// Top level of the sliding-window PDU buffer: request sequencer and window registers.
//
// Sender-side retransmit store keyed by sequence number. Each request gives one
// result. Write, commit, set_current, set_upper, a refused advance and an
// out-of-window write or commit pass through window lookup and execute, and the
// result register is loaded at the end of execute; read_byte adds the S_RDATA
// state for the registered read of the byte RAM and length RAM. advance_lower
// loads its result like a write; when the shift stays below the window size the
// next request is taken as after a write, while a larger shift moves the circular
// base on by the shift modulo the window size through the bit-serial remainder
// unit, and the next request is taken only once that unit is done. The result
// register lets a new request be accepted while a result waits. Writing
// window_size clears all slots at once and resets the edges; it is taken only
// when no request is in flight. No clearing pass follows reset.
module sliding_window_pdu_buffer_top #(
    parameter int MAX_SLOTS = swpb_pkg::MAX_SLOTS_DEF,
    parameter int PDU_BYTES = swpb_pkg::PDU_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  window_size,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  operation,
    input  logic [31:0] seq,
    input  logic [10:0] byte_index,
    input  logic [7:0]  data_byte,
    input  logic [11:0] pdu_length,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  read_data,
    output logic [1:0]  status,
    output logic [31:0] lower_edge,
    output logic [31:0] current_seq,
    output logic [31:0] upper_edge,
    output logic [7:0]  window_open
);

    localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int WS_W   = $clog2(MAX_SLOTS + 1);
    localparam int IDX_W  = (PDU_BYTES > 1) ? $clog2(PDU_BYTES) : 1;
    localparam int LEN_W  = $clog2(PDU_BYTES + 1);
    localparam int ADDR_W = SLOT_W + IDX_W;
    localparam int RST_WS = (swpb_pkg::RESET_WINDOW < MAX_SLOTS) ?
                            swpb_pkg::RESET_WINDOW : MAX_SLOTS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOC,
        S_EXEC,
        S_RDATA,
        S_DIV
    } state_t;

    state_t state_reg, state_next;

    // latched request
    logic [2:0]  op_reg, op_next;
    logic [31:0] seq_reg, seq_next;
    logic [10:0] bidx_reg, bidx_next;
    logic [7:0]  data_reg, data_next;
    logic [11:0] plen_reg, plen_next;

    // window lookup results
    logic              in_win_reg, in_win_next;
    logic              small_reg, small_next;
    logic              not_below_reg, not_below_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [WS_W-1:0]   shift_reg, shift_next;
    logic              rd_ok_reg, rd_ok_next;
    swpb_pkg::status_t rd_st_reg, rd_st_next;

    // window registers
    logic [31:0]       lower_reg, lower_next;
    logic [31:0]       current_reg, current_next;
    logic [31:0]       upper_reg, upper_next;
    logic [SLOT_W-1:0] base_reg, base_next;
    logic [WS_W-1:0]   ws_reg, ws_next;

    // result register
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  rdata_reg, rdata_next;
    logic [1:0]  status_reg, status_next;
    logic [31:0] lower_out_reg, lower_out_next;
    logic [31:0] current_out_reg, current_out_next;
    logic [31:0] upper_out_reg, upper_out_next;
    logic [7:0]  open_reg, open_next;

    // lookup datapath
    logic [31:0]  off;
    logic         in_win;
    logic [WS_W:0] slot_sum;
    logic [WS_W:0] slot_fold;
    logic [WS_W:0] base_sum;
    logic [WS_W:0] base_fold;
    logic         bidx_ok;
    logic         out_free;
    logic [12:0]  plen_ext;
    logic [LEN_W-1:0] commit_len;
    logic [WS_W-1:0]  ws_clamped;

    // submodule links
    swpb_pkg::slot_ctrl_t ctrl;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_addr;
    logic [7:0]        mem_rdata;
    logic [LEN_W-1:0]  rd_len;
    logic              rd_valid;
    logic              div_start;
    logic              div_done;
    logic [WS_W-1:0]   div_rem;

    assign off       = seq_reg - lower_reg;
    assign in_win    = (seq_reg >= lower_reg) && (seq_reg < upper_reg) &&
                       (off < 32'(ws_reg));
    assign slot_sum  = {1'b0, WS_W'(base_reg)} + {1'b0, off[WS_W-1:0]};
    assign slot_fold = (slot_sum >= {1'b0, ws_reg}) ? (slot_sum - {1'b0, ws_reg}) : slot_sum;
    assign base_sum  = {1'b0, WS_W'(base_reg)} + {1'b0, div_rem};
    assign base_fold = (base_sum >= {1'b0, ws_reg}) ? (base_sum - {1'b0, ws_reg}) : base_sum;
    assign bidx_ok   = 32'(bidx_reg) < 32'(PDU_BYTES);
    assign out_free  = !out_valid_reg || out_ready;
    assign plen_ext  = {1'b0, plen_reg};
    assign commit_len = (plen_ext > 13'(PDU_BYTES)) ? LEN_W'(PDU_BYTES) : LEN_W'(plen_reg);
    assign mem_addr  = {slot_reg, IDX_W'(bidx_reg)};

    always_comb
    begin
        if (window_size == 7'd0)
        begin
            ws_clamped = WS_W'(1);
        end
        else if (32'(window_size) > 32'(MAX_SLOTS))
        begin
            ws_clamped = WS_W'(MAX_SLOTS);
        end
        else
        begin
            ws_clamped = WS_W'(window_size);
        end
    end

    assign in_ready  = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        seq_next         = seq_reg;
        bidx_next        = bidx_reg;
        data_next        = data_reg;
        plen_next        = plen_reg;
        in_win_next      = in_win_reg;
        small_next       = small_reg;
        not_below_next   = not_below_reg;
        slot_next        = slot_reg;
        shift_next       = shift_reg;
        rd_ok_next       = rd_ok_reg;
        rd_st_next       = rd_st_reg;
        lower_next       = lower_reg;
        current_next     = current_reg;
        upper_next       = upper_reg;
        base_next        = base_reg;
        ws_next          = ws_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        rdata_next       = rdata_reg;
        status_next      = status_reg;
        lower_out_next   = lower_out_reg;
        current_out_next = current_out_reg;
        upper_out_next   = upper_out_reg;
        open_next        = open_reg;
        ctrl             = '0;
        mem_we           = 1'b0;
        div_start        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cfg_valid)
                begin
                    ws_next      = ws_clamped;
                    lower_next   = '0;
                    current_next = '0;
                    base_next    = '0;
                    upper_next   = 32'(ws_clamped);
                    ctrl.clear_all = 1'b1;
                end
                else if (in_valid)
                begin
                    op_next    = operation;
                    seq_next   = seq;
                    bidx_next  = byte_index;
                    data_next  = data_byte;
                    plen_next  = pdu_length;
                    state_next = S_LOC;
                end
            end
            S_LOC:
            begin
                in_win_next    = in_win;
                small_next     = off < 32'(ws_reg);
                not_below_next = seq_reg >= upper_reg;
                slot_next      = SLOT_W'(slot_fold);
                shift_next     = off[WS_W-1:0];
                state_next     = S_EXEC;
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    status_next = swpb_pkg::ST_OK;
                    state_next  = S_IDLE;
                    unique case (op_reg)
                        swpb_pkg::OP_WRITE_BYTE:
                        begin
                            if (!in_win_reg)
                            begin
                                status_next = swpb_pkg::ST_OUTSIDE;
                            end
                            else
                            begin
                                mem_we = bidx_ok;
                            end
                        end
                        swpb_pkg::OP_COMMIT:
                        begin
                            if (!in_win_reg)
                            begin
                                status_next = swpb_pkg::ST_OUTSIDE;
                            end
                            else
                            begin
                                ctrl.commit  = 1'b1;
                                current_next = current_reg + 32'd1;
                            end
                        end
                        swpb_pkg::OP_ADVANCE:
                        begin
                            if (not_below_reg)
                            begin
                                status_next = swpb_pkg::ST_NOT_BELOW;
                            end
                            else
                            begin
                                ctrl.advance     = 1'b1;
                                ctrl.clear_every = !small_reg;
                                lower_next       = seq_reg;
                                upper_next       = seq_reg + 32'(ws_reg);
                                if (small_reg)
                                begin
                                    base_next = slot_reg;
                                end
                                else
                                begin
                                    // base moves on by the 32-bit shift mod window size
                                    div_start  = 1'b1;
                                    state_next = S_DIV;
                                end
                            end
                        end
                        swpb_pkg::OP_READ_BYTE:
                        begin
                            rd_ok_next = in_win_reg && bidx_ok;
                            rd_st_next = in_win_reg ? swpb_pkg::ST_OK : swpb_pkg::ST_OUTSIDE;
                            state_next = S_RDATA;
                        end
                        swpb_pkg::OP_SET_CURRENT:
                        begin
                            current_next = seq_reg;
                        end
                        swpb_pkg::OP_SET_UPPER:
                        begin
                            upper_next = seq_reg;
                        end
                        default:
                        begin
                        end
                    endcase
                    if (op_reg != swpb_pkg::OP_READ_BYTE)
                    begin
                        out_valid_next   = 1'b1;
                        rdata_next       = '0;
                        lower_out_next   = lower_next;
                        current_out_next = current_next;
                        upper_out_next   = upper_next;
                        open_next        = 8'(upper_next - current_next);
                    end
                end
            end
            S_RDATA:
            begin
                // result register was free on leaving S_EXEC
                out_valid_next   = 1'b1;
                rdata_next       = (rd_ok_reg && rd_valid && (32'(bidx_reg) < 32'(rd_len))) ?
                                   mem_rdata : 8'd0;
                status_next      = rd_st_reg;
                lower_out_next   = lower_reg;
                current_out_next = current_reg;
                upper_out_next   = upper_reg;
                open_next        = 8'(upper_reg - current_reg);
                state_next       = S_IDLE;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    base_next  = SLOT_W'(base_fold);
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            op_reg          <= '0;
            seq_reg         <= '0;
            bidx_reg        <= '0;
            data_reg        <= '0;
            plen_reg        <= '0;
            in_win_reg      <= 1'b0;
            small_reg       <= 1'b0;
            not_below_reg   <= 1'b0;
            slot_reg        <= '0;
            shift_reg       <= '0;
            rd_ok_reg       <= 1'b0;
            rd_st_reg       <= swpb_pkg::ST_OK;
            lower_reg       <= '0;
            current_reg     <= '0;
            upper_reg       <= 32'(RST_WS);
            base_reg        <= '0;
            ws_reg          <= WS_W'(RST_WS);
            out_valid_reg   <= 1'b0;
            rdata_reg       <= '0;
            status_reg      <= '0;
            lower_out_reg   <= '0;
            current_out_reg <= '0;
            upper_out_reg   <= '0;
            open_reg        <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            op_reg          <= op_next;
            seq_reg         <= seq_next;
            bidx_reg        <= bidx_next;
            data_reg        <= data_next;
            plen_reg        <= plen_next;
            in_win_reg      <= in_win_next;
            small_reg       <= small_next;
            not_below_reg   <= not_below_next;
            slot_reg        <= slot_next;
            shift_reg       <= shift_next;
            rd_ok_reg       <= rd_ok_next;
            rd_st_reg       <= rd_st_next;
            lower_reg       <= lower_next;
            current_reg     <= current_next;
            upper_reg       <= upper_next;
            base_reg        <= base_next;
            ws_reg          <= ws_next;
            out_valid_reg   <= out_valid_next;
            rdata_reg       <= rdata_next;
            status_reg      <= status_next;
            lower_out_reg   <= lower_out_next;
            current_out_reg <= current_out_next;
            upper_out_reg   <= upper_out_next;
            open_reg        <= open_next;
        end
    end

    swpb_byte_mem #(
        .ADDR_W (ADDR_W)
    ) u_byte_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_addr),
        .wdata (data_reg),
        .raddr (mem_addr),
        .rdata (mem_rdata)
    );

    swpb_slot_table #(
        .MAX_SLOTS (MAX_SLOTS),
        .SLOT_W    (SLOT_W),
        .WS_W      (WS_W),
        .LEN_W     (LEN_W)
    ) u_slot_table (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .commit_slot (slot_reg),
        .commit_len  (commit_len),
        .base        (base_reg),
        .shift       (shift_reg),
        .ws          (ws_reg),
        .rd_slot     (slot_reg),
        .rd_len      (rd_len),
        .rd_valid    (rd_valid)
    );

    swpb_mod_unit #(
        .WS_W (WS_W)
    ) u_mod_unit (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (off),
        .divisor  (ws_reg),
        .done     (div_done),
        .rem      (div_rem)
    );

    assign out_valid   = out_valid_reg;
    assign read_data   = rdata_reg;
    assign status      = status_reg;
    assign lower_edge  = lower_out_reg;
    assign current_seq = current_out_reg;
    assign upper_edge  = upper_out_reg;
    assign window_open = open_reg;

`ifndef SYNTHESIS
    a_base_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(base_reg) < 32'(ws_reg)) && (ws_reg != '0) && (32'(ws_reg) <= 32'(MAX_SLOTS)))
        else $error("circular base or window size out of range");

    a_cfg_resets_edges: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready) |=>
            (lower_reg == '0) && (current_reg == '0) && (base_reg == '0) &&
            (upper_reg == 32'(ws_reg)))
        else $error("window size write did not reset the edges");

    a_rem_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("remainder result outside base update");

    a_read_follows_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RDATA) |-> ($past(state_reg) == S_EXEC) && !$past(out_valid_reg && !out_ready))
        else $error("read data stage entered without a free result register");
`endif

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the sliding-window PDU buffer: directed table, then random traffic.
module tb;

    localparam int          NUM_SLOTS   = swpb_pkg::MAX_SLOTS_DEF;
    localparam int          SLOT_BYTES  = swpb_pkg::PDU_BYTES_DEF;
    localparam int          STALL_LIMIT = 2000;
    localparam logic [2:0]  OP_SPARE_6  = 3'd6;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] seq;
        logic [10:0] byte_index;
        logic [7:0]  data_byte;
        logic [11:0] pdu_length;
    } request_t;

    typedef struct packed {
        logic [7:0]        read_data;
        swpb_pkg::status_t status;
        logic [31:0]       lower_edge;
        logic [31:0]       current_seq;
        logic [31:0]       upper_edge;
        logic [7:0]        window_open;
    } window_result_t;

    typedef struct packed {
        request_t       req;
        logic           fixed;
        window_result_t want;
    } directed_row_t;

    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_COIN,
        SINK_MOSTLY,
        SINK_PERIODIC
    } sink_mode_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [6:0]  window_size;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  operation;
    logic [31:0] seq;
    logic [10:0] byte_index;
    logic [7:0]  data_byte;
    logic [11:0] pdu_length;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  read_data;
    logic [1:0]  status;
    logic [31:0] lower_edge;
    logic [31:0] current_seq;
    logic [31:0] upper_edge;
    logic [7:0]  window_open;

    // Window shadow state
    logic [7:0]  pdu_mem [int unsigned];
    logic [10:0] stored_idx [NUM_SLOTS][$];
    logic [11:0] slot_len [NUM_SLOTS];
    logic        slot_live [NUM_SLOTS];
    logic [31:0] win_lower;
    logic [31:0] win_current;
    logic [31:0] win_upper;
    int unsigned win_base;
    int unsigned win_slots;

    window_result_t pending_results [$];
    int unsigned    accepted_cnt = 0;
    int unsigned    mismatches = 0;
    int             burst_left = 0;

    sliding_window_pdu_buffer_top u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .window_size (window_size),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .operation   (operation),
        .seq         (seq),
        .byte_index  (byte_index),
        .data_byte   (data_byte),
        .pdu_length  (pdu_length),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .read_data   (read_data),
        .status      (status),
        .lower_edge  (lower_edge),
        .current_seq (current_seq),
        .upper_edge  (upper_edge),
        .window_open (window_open)
    );

    always #4 clk = ~clk;

    // Rows flagged fixed carry a hand-computed result; the rest go through the predictor.
    directed_row_t directed_rows [24] = '{
        '{'{swpb_pkg::OP_READ_BYTE,   32'd0,         11'd0,    8'h00, 12'd0},    1'b1,
          '{8'h00, swpb_pkg::ST_OK,        32'd0, 32'd0, 32'd16, 8'd16}},
        '{'{swpb_pkg::OP_WRITE_BYTE,  32'd0,         11'd0,    8'hFF, 12'd0},    1'b1,
          '{8'h00, swpb_pkg::ST_OK,        32'd0, 32'd0, 32'd16, 8'd16}},
        '{'{swpb_pkg::OP_WRITE_BYTE,  32'd0,         11'd2047, 8'h00, 12'd0},    1'b1,
          '{8'h00, swpb_pkg::ST_OK,        32'd0, 32'd0, 32'd16, 8'd16}},
        '{'{swpb_pkg::OP_COMMIT,      32'd0,         11'd0,    8'h00, 12'd4095}, 1'b1,
          '{8'h00, swpb_pkg::ST_OK,        32'd0, 32'd1, 32'd16, 8'd15}},
        '{'{swpb_pkg::OP_READ_BYTE,   32'd0,         11'd2047, 8'h00, 12'd0},    1'b0, '0},
        '{'{swpb_pkg::OP_READ_BYTE,   32'd0,         11'd0,    8'h00, 12'd0},    1'b0, '0},
        '{'{swpb_pkg::OP_WRITE_BYTE,  32'd16,        11'd0,    8'h00, 12'd0},    1'b1,
          '{8'h00, swpb_pkg::ST_OUTSIDE,   32'd0, 32'd1, 32'd16, 8'd15}},
        '{'{swpb_pkg::OP_COMMIT,      32'hFFFF_FFFF, 11'd0,    8'h00, 12'd7},    1'b1,
          '{8'h00, swpb_pkg::ST_OUTSIDE,   32'd0, 32'd1, 32'd16, 8'd15}},
        '{'{swpb_pkg::OP_READ_BYTE,   32'hFFFF_FFFF, 11'd2047, 8'h00, 12'd0},    1'b1,
          '{8'h00, swpb_pkg::ST_OUTSIDE,   32'd0, 32'd1, 32'd16, 8'd15}},
        '{'{swpb_pkg::OP_WRITE_BYTE,  32'd1,         11'd3,    8'h5A, 12'd0},    1'b0, '0},
        '{'{swpb_pkg::OP_COMMIT,      32'd1,         11'd0,    8'h00, 12'd0},    1'b0, '0},
        '{'{swpb_pkg::OP_READ_BYTE,   32'd1,         11'd3,    8'h00, 12'd0},    1'b0, '0},
        '{'{swpb_pkg::OP_COMMIT,      32'd15,        11'd0,    8'h00, 12'd2049}, 1'b0, '0},
        '{'{OP_SPARE_6,               32'd5,         11'd9,    8'h11, 12'd9},    1'b0, '0},
        '{'{swpb_pkg::OP_ADVANCE,     32'd16,        11'd0,    8'h00, 12'd0},    1'b1,
          '{8'h00, swpb_pkg::ST_NOT_BELOW, 32'd0, 32'd3, 32'd16, 8'd13}},
        '{'{swpb_pkg::OP_ADVANCE,     32'd2,         11'd0,    8'h00, 12'd0},    1'b0, '0},
        // back below lower: the shift wraps and drops every slot
        '{'{swpb_pkg::OP_ADVANCE,     32'd1,         11'd0,    8'h00, 12'd0},    1'b0, '0},
        '{'{swpb_pkg::OP_SET_CURRENT, 32'hFFFF_FFFF, 11'd0,    8'h00, 12'd0},    1'b0, '0},
        '{'{swpb_pkg::OP_SET_UPPER,   32'd0,         11'd0,    8'h00, 12'd0},    1'b0, '0},
        '{'{swpb_pkg::OP_WRITE_BYTE,  32'd1,         11'd1,    8'h3C, 12'd0},    1'b0, '0},
        '{'{swpb_pkg::OP_SET_UPPER,   32'hFFFF_FFFF, 11'd0,    8'h00, 12'd0},    1'b0, '0},
        // upper wraps past zero here
        '{'{swpb_pkg::OP_ADVANCE,     32'hFFFF_FFF0, 11'd0,    8'h00, 12'd0},    1'b0, '0},
        '{'{swpb_pkg::OP_WRITE_BYTE,  32'hFFFF_FFF0, 11'd7,    8'hC3, 12'd0},    1'b0, '0},
        '{'{swpb_pkg::OP_ADVANCE,     32'd0,         11'd0,    8'h00, 12'd0},    1'b0, '0}
    };

    function automatic void reopen_window(logic [6:0] size);
        win_slots = (size == 0) ? 1 : (size > NUM_SLOTS) ? NUM_SLOTS : size;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            slot_live[i] = 1'b0;
            slot_len[i]  = '0;
        end
        win_lower   = '0;
        win_current = '0;
        win_base    = 0;
        win_upper   = win_slots;
    endfunction

    function automatic bit find_slot(logic [31:0] s, output int unsigned slot);
        logic [31:0] off;
        off  = s - win_lower;
        slot = 0;
        if (s < win_lower || s >= win_upper || off >= win_slots)
            return 1'b0;
        slot = (win_base + off) % win_slots;
        return 1'b1;
    endfunction

    function automatic window_result_t predict_window_result(request_t r);
        window_result_t res;
        int unsigned    slot;
        int unsigned    key;
        logic [31:0]    shift;
        logic [31:0]    open_gap;
        int unsigned    n;
        res = '0;
        res.status = swpb_pkg::ST_OK;
        case (r.op)
            swpb_pkg::OP_WRITE_BYTE:
            begin
                if (!find_slot(r.seq, slot))
                    res.status = swpb_pkg::ST_OUTSIDE;
                else
                begin
                    key = slot * SLOT_BYTES + r.byte_index;
                    if (!pdu_mem.exists(key))
                        stored_idx[slot].push_back(r.byte_index);
                    pdu_mem[key] = r.data_byte;
                end
            end
            swpb_pkg::OP_COMMIT:
            begin
                if (!find_slot(r.seq, slot))
                    res.status = swpb_pkg::ST_OUTSIDE;
                else
                begin
                    slot_len[slot]  = (r.pdu_length > SLOT_BYTES) ? 12'(SLOT_BYTES) : r.pdu_length;
                    slot_live[slot] = 1'b1;
                    win_current++;
                end
            end
            swpb_pkg::OP_ADVANCE:
            begin
                if (r.seq >= win_upper)
                    res.status = swpb_pkg::ST_NOT_BELOW;
                else
                begin
                    shift = r.seq - win_lower;
                    n = (shift < win_slots) ? shift : win_slots;
                    for (int i = 0; i < n; i++)
                    begin
                        slot_live[(win_base + i) % win_slots] = 1'b0;
                        slot_len[(win_base + i) % win_slots]  = '0;
                    end
                    win_base  = (win_base + shift % win_slots) % win_slots;
                    win_lower = r.seq;
                    win_upper = r.seq + win_slots;
                end
            end
            swpb_pkg::OP_READ_BYTE:
            begin
                if (!find_slot(r.seq, slot))
                    res.status = swpb_pkg::ST_OUTSIDE;
                else if (slot_live[slot] && r.byte_index < slot_len[slot])
                begin
                    key = slot * SLOT_BYTES + r.byte_index;
                    res.read_data = pdu_mem.exists(key) ? pdu_mem[key] : 8'h00;
                end
            end
            swpb_pkg::OP_SET_CURRENT: win_current = r.seq;
            swpb_pkg::OP_SET_UPPER:   win_upper = r.seq;
            default: ;
        endcase
        open_gap = win_upper - win_current;
        res.lower_edge  = win_lower;
        res.current_seq = win_current;
        res.upper_edge  = win_upper;
        res.window_open = open_gap[7:0];
        return res;
    endfunction

    function automatic logic [10:0] pick_stored_index(logic [31:0] s);
        int unsigned slot;
        if (find_slot(s, slot) && stored_idx[slot].size() != 0 && $urandom_range(0, 4) != 0)
            return stored_idx[slot][$urandom_range(0, stored_idx[slot].size() - 1)];
        return 11'($urandom_range(0, 2047));
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Drive one request, hold it until taken, then record what it should return.
    task automatic issue_request(input request_t r, input logic fixed,
                                 input window_result_t want);
        window_result_t res;
        in_valid   <= 1'b1;
        operation  <= r.op;
        seq        <= r.seq;
        byte_index <= r.byte_index;
        data_byte  <= r.data_byte;
        pdu_length <= r.pdu_length;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        res = predict_window_result(r);
        pending_results.push_back(fixed ? want : res);
        accepted_cnt++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 90)
                                                     : $urandom_range(0, 12);
        end
    endtask

    task automatic send_op(input logic [2:0] op, input logic [31:0] s, input logic [10:0] bidx,
                           input logic [7:0] d, input logic [11:0] len);
        request_t    r;
        int unsigned slot;
        r = '{op, s, bidx, d, len};
        // a read, within a committed length, of a byte nothing has stored yet becomes a write to it
        if (op == swpb_pkg::OP_READ_BYTE && find_slot(s, slot))
        begin
            if (slot_live[slot] && bidx < slot_len[slot]
                && !pdu_mem.exists(slot * SLOT_BYTES + bidx))
            begin
                r.op        = swpb_pkg::OP_WRITE_BYTE;
                r.data_byte = 8'($urandom);
            end
        end
        issue_request(r, 1'b0, '0);
    endtask

    task automatic write_window(input logic [6:0] size);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        cfg_valid   <= 1'b1;
        window_size <= size;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        reopen_window(size);
    endtask

    task automatic run_traffic(input int unsigned n_items);
        int unsigned stop_at;
        int unsigned pick;
        logic [31:0] s;
        logic [2:0]  op;
        stop_at = accepted_cnt + n_items;
        while (accepted_cnt < stop_at)
        begin
            pick = $urandom_range(0, 99);
            s = win_lower + $urandom_range(0, win_slots - 1);
            if (pick < 45)
            begin
                // fill a PDU, commit it, read some of it back
                repeat ($urandom_range(1, 5))
                    send_op(swpb_pkg::OP_WRITE_BYTE, s,
                            ($urandom_range(0, 3) == 0) ? 11'd2047 : 11'($urandom_range(0, 63)),
                            8'($urandom), 12'd0);
                send_op(swpb_pkg::OP_COMMIT, s, 11'd0, 8'd0,
                        ($urandom_range(0, 9) == 0) ? 12'($urandom_range(0, 4095))
                                                    : 12'($urandom_range(1, 2048)));
                repeat ($urandom_range(0, 3))
                    send_op(swpb_pkg::OP_READ_BYTE, s, pick_stored_index(s), 8'd0, 12'd0);
            end
            else if (pick < 62)
                send_op(swpb_pkg::OP_READ_BYTE, s, pick_stored_index(s), 8'd0, 12'd0);
            else if (pick < 76)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5:
                        s = win_lower + $urandom_range(1, win_slots);
                    6, 7:
                        s = win_lower - $urandom_range(1, 4);
                    default:
                        s = win_upper - $urandom_range(0, 1);
                endcase
                send_op(swpb_pkg::OP_ADVANCE, s, 11'd0, 8'd0, 12'd0);
            end
            else if (pick < 84)
            begin
                if ($urandom_range(0, 1) == 0)
                    send_op(swpb_pkg::OP_SET_UPPER,
                            win_lower + win_slots + $urandom_range(0, 3 * win_slots),
                            11'd0, 8'd0, 12'd0);
                else
                    send_op(swpb_pkg::OP_SET_CURRENT, win_lower + $urandom_range(0, win_slots),
                            11'd0, 8'd0, 12'd0);
            end
            else if (pick < 94)
                send_op(3'($urandom_range(0, 7)), $urandom, 11'($urandom_range(0, 2047)),
                        8'($urandom), 12'($urandom_range(0, 4095)));
            else
            begin
                case ($urandom_range(0, 2))
                    0:       op = swpb_pkg::OP_WRITE_BYTE;
                    1:       op = swpb_pkg::OP_COMMIT;
                    default: op = swpb_pkg::OP_READ_BYTE;
                endcase
                s = ($urandom_range(0, 1) == 0) ? win_upper + $urandom_range(0, 3)
                                                : win_lower - 1 - $urandom_range(0, 3);
                send_op(op, s, 11'($urandom_range(0, 2047)), 8'($urandom),
                        12'($urandom_range(0, 4095)));
            end
        end
    endtask

    always @(posedge clk)
    begin
        window_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with no request outstanding, status %0d lower %0h",
                         $time, status, lower_edge);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("read_data", want.read_data, read_data);
                check_field("status", want.status, status);
                check_field("lower_edge", want.lower_edge, lower_edge);
                check_field("current_seq", want.current_seq, current_seq);
                check_field("upper_edge", want.upper_edge, upper_edge);
                check_field("window_open", want.window_open, window_open);
            end
        end
    end

    // Result side: random stall modes take turns; one long hold after 300 accepted requests fills the block.
    initial
    begin
        sink_mode_t  mode;
        int unsigned mode_left;
        int unsigned hold_left;
        int unsigned tick;
        bit          held;
        mode      = SINK_OPEN;
        mode_left = 0;
        hold_left = 0;
        tick      = 0;
        held      = 1'b0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            tick++;
            if (!held && accepted_cnt >= 300)
            begin
                held      = 1'b1;
                hold_left = 150;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = sink_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                case (mode)
                    SINK_OPEN:   out_ready <= 1'b1;
                    SINK_COIN:   out_ready <= 1'($urandom_range(0, 1));
                    SINK_MOSTLY: out_ready <= ($urandom_range(0, 7) != 0);
                    default:     out_ready <= (tick % 5 < 2);
                endcase
            end
        end
    end

    initial
    begin
        int unsigned idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no request or result moved for %0d cycles", $time, STALL_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        logic [6:0] sizes [9];
        sizes = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd5, 7'd37, 7'd100, 7'd2, 7'd16};
        rst_n       <= 1'b0;
        cfg_valid   <= 1'b0;
        window_size <= 7'(swpb_pkg::RESET_WINDOW);
        in_valid    <= 1'b0;
        operation   <= swpb_pkg::OP_WRITE_BYTE;
        seq         <= '0;
        byte_index  <= '0;
        data_byte   <= '0;
        pdu_length  <= '0;
        reopen_window(7'(swpb_pkg::RESET_WINDOW));
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            issue_request(directed_rows[i].req, directed_rows[i].fixed, directed_rows[i].want);

        foreach (sizes[i])
        begin
            write_window(sizes[i]);
            run_traffic(72);
        end

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
